// ===== sv/tkss_pkg.sv =====
// Shared types and constants of the top-k smallest score keeper.
`timescale 1ns / 1ps
`default_nettype none

package tkss_pkg;

  localparam int IN_SCORE_BITS = 20;
  localparam int FRAME_BITS    = 16;
  localparam int LIMIT_BITS    = 4;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PROC = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } tkss_state_t;

endpackage

`default_nettype wire

// ===== sv/tkss_slot_mem.sv =====
// Slot store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tkss_slot_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 36,
  parameter int AW    = 3
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/top_k_smallest_score_keeper.sv =====
// Top level of the top-k smallest score keeper: control sequencer around the slot store.
`timescale 1ns / 1ps
`default_nettype none

// A candidate is taken when start is high and busy is low, so a new candidate is taken only
// once the last one is through. A candidate that fills a free slot, or that is dropped, keeps
// busy high only for the S_PROC state. A candidate that replaces a kept entry keeps busy high
// through S_PROC and S_SCAN: the slot store has one read port, and the replacement pass
// reads every kept slot once to place the candidate and recompute the kept maximum. A
// candidate marked last adds the S_EMIT state, in which the kept entries come out in slot
// order, one per cycle, each shown for one cycle with out_strobe high and the final one
// flagged by out_end_of_list. The receiver cannot stall these results. keep_limit is written
// through cfg_we and cfg_wdata and should change only while busy is low; values above
// MAX_SLOTS act as MAX_SLOTS.
module top_k_smallest_score_keeper
  import tkss_pkg::*;
#(
  parameter int MAX_SLOTS  = 8,
  parameter int SCORE_BITS = 20
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [IN_SCORE_BITS-1:0] in_score,
  input  wire logic [FRAME_BITS-1:0]    in_frame_index,
  input  wire logic                     in_last_candidate,
  output logic                          out_strobe,
  output logic      [IN_SCORE_BITS-1:0] out_kept_score,
  output logic      [FRAME_BITS-1:0]    out_kept_frame,
  output logic                          out_end_of_list,
  input  wire logic                     cfg_we,
  input  wire logic [LIMIT_BITS-1:0]    cfg_wdata
);

  localparam int SW      = (SCORE_BITS < IN_SCORE_BITS) ? SCORE_BITS : IN_SCORE_BITS;
  localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W   = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;
  localparam int ENTRY_W = SW + FRAME_BITS;

  localparam logic [IN_SCORE_BITS-1:0] SCORE_CAP = (SCORE_BITS >= IN_SCORE_BITS) ?
      {IN_SCORE_BITS{1'b1}} : IN_SCORE_BITS'((64'd1 << SCORE_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

  tkss_state_t state_r, state_nxt;

  logic [LIMIT_BITS-1:0] keep_limit_r;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [SW-1:0]         largest_r, largest_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_W-1:0]     chk_idx_r;
  logic                  chk_vld_r, chk_vld_nxt;
  logic                  hit_r, hit_nxt;
  logic [SW-1:0]         top_r, top_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  logic                  out_end_r, out_end_nxt;

  logic [SW-1:0]         cand_score_r;
  logic [FRAME_BITS-1:0] cand_frame_r;
  logic                  cand_last_r;
  logic [IN_SCORE_BITS-1:0] sat_score;

  logic                  append, drop;
  logic                  rd_en, wr_en, hit_now;
  logic [SLOT_W-1:0]     rd_addr, wr_addr;
  logic [ENTRY_W-1:0]    rd_data, wr_data;
  logic [SW-1:0]         rd_sc, cur_val;
  logic [FRAME_BITS-1:0] rd_fr;

  assign sat_score = (in_score > SCORE_CAP) ? SCORE_CAP : in_score;

  assign rd_sc = rd_data[ENTRY_W-1 -: SW];
  assign rd_fr = rd_data[FRAME_BITS-1:0];

  assign append  = (CMP_W'(used_r) < CMP_W'(keep_limit_r)) && (used_r < MAX_CNT);
  assign drop    = (cand_score_r > largest_r) || (used_r == '0);

  assign rd_en   = ((state_r == S_SCAN) || (state_r == S_EMIT)) && (idx_r < used_r);
  assign rd_addr = idx_r[SLOT_W-1:0];

  // The first slot that still equals the kept maximum takes the candidate.
  assign hit_now = (state_r == S_SCAN) && chk_vld_r && !hit_r && (rd_sc == largest_r);
  assign cur_val = hit_now ? cand_score_r : rd_sc;

  assign wr_en   = ((state_r == S_PROC) && append) || hit_now;
  assign wr_addr = hit_now ? chk_idx_r : used_r[SLOT_W-1:0];
  assign wr_data = {cand_score_r, cand_frame_r};

  tkss_slot_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (ENTRY_W),
    .AW    (SLOT_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    largest_nxt    = largest_r;
    idx_nxt        = idx_r;
    chk_vld_nxt    = 1'b0;
    hit_nxt        = hit_r;
    top_nxt        = top_r;
    out_strobe_nxt = 1'b0;
    out_end_nxt    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        idx_nxt = '0;
        if (append) begin
          used_nxt = used_r + CNT_W'(1);
          if (cand_score_r > largest_r) begin
            largest_nxt = cand_score_r;
          end
          state_nxt = cand_last_r ? S_EMIT : S_IDLE;
        end else if (drop) begin
          state_nxt = cand_last_r ? S_EMIT : S_IDLE;
        end else begin
          hit_nxt   = 1'b0;
          top_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        chk_vld_nxt = rd_en;
        if (rd_en) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          if (cur_val > top_r) begin
            top_nxt = cur_val;
          end
          if (hit_now) begin
            hit_nxt = 1'b1;
          end
        end
        // The last slot is checked in the cycle where no further read is issued.
        if (!rd_en) begin
          if (hit_r || hit_now) begin
            largest_nxt = top_nxt;
          end
          idx_nxt   = '0;
          state_nxt = cand_last_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (rd_en) begin
          out_strobe_nxt = 1'b1;
          out_end_nxt    = ((idx_r + CNT_W'(1)) == used_r);
          idx_nxt        = idx_r + CNT_W'(1);
        end else begin
          used_nxt    = '0;
          largest_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      keep_limit_r <= LIMIT_RESET;
      used_r       <= '0;
      largest_r    <= '0;
      idx_r        <= '0;
      chk_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      out_strobe_r <= 1'b0;
      out_end_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      largest_r    <= largest_nxt;
      idx_r        <= idx_nxt;
      chk_vld_r    <= chk_vld_nxt;
      hit_r        <= hit_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_end_r    <= out_end_nxt;
      if (cfg_we) begin
        keep_limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    chk_idx_r <= rd_addr;
    if ((state_r == S_IDLE) && start) begin
      cand_score_r <= sat_score[SW-1:0];
      cand_frame_r <= in_frame_index;
      cand_last_r  <= in_last_candidate;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_kept_score  = IN_SCORE_BITS'(rd_sc);
  assign out_kept_frame  = rd_fr;
  assign out_end_of_list = out_end_r;

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= MAX_CNT)
    else $error("kept entry count exceeds the slot count");

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_EMIT))
    else $error("result strobe outside of the emission sequence");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_end_of_list) |=> (used_r == '0) && (largest_r == '0))
    else $error("store not cleared after the final result");

  a_start_takes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_scan_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_r && (state_r == S_SCAN)) |-> !hit_now)
    else $error("replacement pass placed the candidate twice");

endmodule

`default_nettype wire

// ===== tb/tb_top_k_smallest_score_keeper.sv =====
// Testbench for the top-k smallest score keeper: directed table, random runs, score tracker.
`timescale 1ns / 1ps

module tb_top_k_smallest_score_keeper
  import tkss_pkg::*;
();

  localparam int KEEP_SLOTS     = 8;
  localparam int ITEM_TARGET    = 350;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIR_ROWS       = 30;

  typedef enum logic {ROW_CAND, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_SILENT, CHK_SINGLE} row_check_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [LIMIT_BITS-1:0]    cfg_val;
    logic [IN_SCORE_BITS-1:0] score;
    logic [FRAME_BITS-1:0]    frame;
    logic                     last;
    row_check_t               chk;
    logic [IN_SCORE_BITS-1:0] t_score;
    logic [FRAME_BITS-1:0]    t_frame;
  } stim_row_t;

  typedef struct packed {
    logic [IN_SCORE_BITS-1:0] score;
    logic [FRAME_BITS-1:0]    frame;
    logic                     eol;
  } kept_entry_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [IN_SCORE_BITS-1:0] in_score = '0;
  logic [FRAME_BITS-1:0]    in_frame_index = '0;
  logic                     in_last_candidate = 1'b0;
  logic                     out_strobe;
  logic [IN_SCORE_BITS-1:0] out_kept_score;
  logic [FRAME_BITS-1:0]    out_kept_frame;
  logic                     out_end_of_list;
  logic                     cfg_we = 1'b0;
  logic [LIMIT_BITS-1:0]    cfg_wdata = '0;

  // Tracker of the kept list, as the block should hold it.
  logic [IN_SCORE_BITS-1:0] held_score [KEEP_SLOTS];
  logic [FRAME_BITS-1:0]    held_frame [KEEP_SLOTS];
  int                       held_count = 0;
  logic [IN_SCORE_BITS-1:0] held_max = '0;
  logic [LIMIT_BITS-1:0]    limit_reg = LIMIT_RESET;

  kept_entry_t pending_kept [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          cand_sent = 0;
  int          idle_pct = 0;

  // Directed candidates and limit writes. Single-result rows carry their expected entry.
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_CAND, 4'd0,  20'h12345, 16'hABCD, 1'b1, CHK_SINGLE,  20'h12345, 16'hABCD},
    '{ROW_CAND, 4'd0,  20'hFFFFF, 16'hFFFF, 1'b1, CHK_SINGLE,  20'hFFFFF, 16'hFFFF},
    '{ROW_CAND, 4'd0,  20'h00000, 16'h0000, 1'b1, CHK_SINGLE,  20'h00000, 16'h0000},
    '{ROW_CFG,  4'd1,  20'd0,     16'h0000, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd500,   16'h0001, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd300,   16'h0002, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd700,   16'h0003, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd300,   16'h0004, 1'b1, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CFG,  4'd0,  20'd0,     16'h0000, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd0,     16'h0005, 1'b1, CHK_SILENT,  20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd5,     16'h0006, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd9,     16'h0007, 1'b1, CHK_SILENT,  20'd0,     16'h0000},
    '{ROW_CFG,  4'd15, 20'd0,     16'h0000, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd40,    16'h0010, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd10,    16'h0011, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd40,    16'h0012, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd25,    16'h0013, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd40,    16'h0014, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd5,     16'h0015, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd30,    16'h0016, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd40,    16'h0017, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd20,    16'h0018, 1'b1, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CFG,  4'd4,  20'd0,     16'h0000, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd100,   16'h0020, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd200,   16'h0021, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd300,   16'h0022, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CFG,  4'd2,  20'd0,     16'h0000, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd150,   16'h0023, 1'b0, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CAND, 4'd0,  20'd1000,  16'h0024, 1'b1, CHK_PREDICT, 20'd0,     16'h0000},
    '{ROW_CFG,  4'd8,  20'd0,     16'h0000, 1'b0, CHK_PREDICT, 20'd0,     16'h0000}
  };

  int phase_pct [4] = '{0, 79, 0, 12};

  top_k_smallest_score_keeper u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_score          (in_score),
    .in_frame_index    (in_frame_index),
    .in_last_candidate (in_last_candidate),
    .out_strobe        (out_strobe),
    .out_kept_score    (out_kept_score),
    .out_kept_frame    (out_kept_frame),
    .out_end_of_list   (out_end_of_list),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Appends one expected entry at the tail of the queue.
  task automatic queue_kept(input kept_entry_t e);
    pending_kept.insert(pending_kept.size(), e);
  endtask

  // Updates the tracked list with one candidate and queues the entries a last candidate emits.
  task automatic track_candidate(input logic [IN_SCORE_BITS-1:0] s,
                                 input logic [FRAME_BITS-1:0] f, input logic last,
                                 input bit queue_results);
    int                       cap;
    int                       hit;
    logic [IN_SCORE_BITS-1:0] top;
    cap = (limit_reg > KEEP_SLOTS) ? KEEP_SLOTS : int'(limit_reg);
    if (held_count < cap) begin
      held_score[held_count] = s;
      held_frame[held_count] = f;
      held_count++;
      if (s > held_max) held_max = s;
    end else if (s <= held_max) begin
      hit = -1;
      for (int i = 0; i < held_count; i++) begin
        if (hit < 0 && held_score[i] == held_max) hit = i;
      end
      // With an empty store nothing matches and the candidate is dropped.
      if (hit >= 0) begin
        held_score[hit] = s;
        held_frame[hit] = f;
        top = '0;
        for (int i = 0; i < held_count; i++) begin
          if (held_score[i] > top) top = held_score[i];
        end
        held_max = top;
      end
    end
    if (last) begin
      if (queue_results) begin
        for (int i = 0; i < held_count; i++) begin
          queue_kept(kept_entry_t'{held_score[i], held_frame[i], i == held_count - 1});
        end
      end
      held_count = 0;
      held_max = '0;
    end
  endtask

  // Entered after a rising edge; returns at the edge that accepts the transaction.
  task automatic send_candidate(input logic [IN_SCORE_BITS-1:0] s,
                                input logic [FRAME_BITS-1:0] f, input logic last,
                                input bit queue_results);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_score = s;
    in_frame_index = f;
    in_last_candidate = last;
    do @(posedge clk); while (busy);
    track_candidate(s, f, last, queue_results);
    cand_sent++;
  endtask

  // Holds off the sender until every expected entry is out and the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_kept.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] v);
    settle();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    limit_reg = v;
  endtask

  function automatic logic [LIMIT_BITS-1:0] pick_limit();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return 4'd0;
      1:       return 4'd15;
      2:       return LIMIT_BITS'($urandom_range(9, 14));
      default: return LIMIT_BITS'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    kept_entry_t want;
    if (rst_n && out_strobe) begin
      if (pending_kept.size() == 0) begin
        report($sformatf("unexpected entry score=%0d frame=%0d end=%0b",
                         out_kept_score, out_kept_frame, out_end_of_list));
      end else begin
        want = pending_kept.pop_front();
        if (out_kept_score !== want.score || out_kept_frame !== want.frame ||
            out_end_of_list !== want.eol) begin
          report($sformatf("expected score=%0d frame=%0d end=%0b, got score=%0d frame=%0d end=%0b",
                           want.score, want.frame, want.eol,
                           out_kept_score, out_kept_frame, out_end_of_list));
        end
      end
    end
    // A stuck block shows up as a long stretch with neither a transaction nor an entry.
    if ((start && !busy) || out_strobe) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t                row;
    int                       run_len;
    int                       style;
    logic [IN_SCORE_BITS-1:0] s;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        write_limit(row.cfg_val);
      end else begin
        if (row.chk == CHK_SINGLE) queue_kept(kept_entry_t'{row.t_score, row.t_frame, 1'b1});
        send_candidate(row.score, row.frame, row.last, row.chk == CHK_PREDICT);
      end
    end

    while (cand_sent < ITEM_TARGET) begin
      idle_pct = phase_pct[(cand_sent / 88) % 4];
      if ($urandom_range(0, 3) == 0) write_limit(pick_limit());
      run_len = $urandom_range(1, 12);
      style = $urandom_range(0, 3);
      for (int k = 0; k < run_len; k++) begin
        // Now and then the limit changes while a run is partly kept.
        if (k > 0 && $urandom_range(0, 24) == 0) write_limit(pick_limit());
        case (style)
          0:       s = IN_SCORE_BITS'($urandom_range(0, 7));
          1:       s = IN_SCORE_BITS'($urandom());
          2:       s = IN_SCORE_BITS'($urandom_range(0, 255));
          default: s = $urandom_range(0, 1) ? '1 : IN_SCORE_BITS'($urandom_range(0, 3));
        endcase
        send_candidate(s, FRAME_BITS'($urandom()), k == run_len - 1, 1'b1);
      end
    end

    settle();
    if (mismatch_count == 0 && pending_kept.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tkss_pkg.sv
sv/tkss_slot_mem.sv
sv/top_k_smallest_score_keeper.sv
tb/tb_top_k_smallest_score_keeper.sv
